@@ rtl/core/affmi_pkg.sv @@
package affmi_pkg;

  localparam int ELEM_COUNT = 12;
  localparam int LAST_IDX   = 11;
  localparam int RECIP_W    = 48;
  localparam int QUOT_W     = RECIP_W - 1;
  localparam int MEM_DEPTH  = 36;
  localparam int MEM_AW     = 6;
  localparam int PC_W       = 6;
  localparam logic [MEM_AW-1:0] A_INV = 6'd24;

  typedef struct packed {
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         result_index;
    logic signed [31:0] result_value;
    logic               singular;
    logic               last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_MUL, OP_MULR, OP_ADD, OP_SUB, OP_NEG, OP_DIV, OP_END
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_EXEC, ST_MULW, ST_DIVW, ST_OUT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [MEM_AW-1:0] a;
    logic [MEM_AW-1:0] b;
    logic [MEM_AW-1:0] d;
  } uop_t;

  function automatic uop_t mk(op_t op, int a, int b, int d);
    uop_t u;
    u.op = op;
    u.a  = MEM_AW'(a);
    u.b  = MEM_AW'(b);
    u.d  = MEM_AW'(d);
    return u;
  endfunction

  // Scratch map: 0-11 source, 12-20 adjugate, 21/22 temps, 23 det, 24-35 inverse.
  function automatic uop_t rom(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_MUL, 4, 8, 21);
      6'd1:  u = mk(OP_MUL, 5, 7, 22);
      6'd2:  u = mk(OP_SUB, 21, 22, 12);
      6'd3:  u = mk(OP_MUL, 2, 7, 21);
      6'd4:  u = mk(OP_MUL, 1, 8, 22);
      6'd5:  u = mk(OP_SUB, 21, 22, 13);
      6'd6:  u = mk(OP_MUL, 1, 5, 21);
      6'd7:  u = mk(OP_MUL, 2, 4, 22);
      6'd8:  u = mk(OP_SUB, 21, 22, 14);
      6'd9:  u = mk(OP_MUL, 5, 6, 21);
      6'd10: u = mk(OP_MUL, 3, 8, 22);
      6'd11: u = mk(OP_SUB, 21, 22, 15);
      6'd12: u = mk(OP_MUL, 0, 8, 21);
      6'd13: u = mk(OP_MUL, 2, 6, 22);
      6'd14: u = mk(OP_SUB, 21, 22, 16);
      6'd15: u = mk(OP_MUL, 2, 3, 21);
      6'd16: u = mk(OP_MUL, 0, 5, 22);
      6'd17: u = mk(OP_SUB, 21, 22, 17);
      6'd18: u = mk(OP_MUL, 3, 7, 21);
      6'd19: u = mk(OP_MUL, 4, 6, 22);
      6'd20: u = mk(OP_SUB, 21, 22, 18);
      6'd21: u = mk(OP_MUL, 1, 6, 21);
      6'd22: u = mk(OP_MUL, 0, 7, 22);
      6'd23: u = mk(OP_SUB, 21, 22, 19);
      6'd24: u = mk(OP_MUL, 0, 4, 21);
      6'd25: u = mk(OP_MUL, 1, 3, 22);
      6'd26: u = mk(OP_SUB, 21, 22, 20);
      6'd27: u = mk(OP_MUL, 0, 12, 23);
      6'd28: u = mk(OP_MUL, 1, 15, 21);
      6'd29: u = mk(OP_ADD, 23, 21, 23);
      6'd30: u = mk(OP_MUL, 2, 18, 21);
      6'd31: u = mk(OP_ADD, 23, 21, 23);
      6'd32: u = mk(OP_DIV, 23, 0, 0);
      6'd33: u = mk(OP_MULR, 12, 0, 24);
      6'd34: u = mk(OP_MULR, 13, 0, 25);
      6'd35: u = mk(OP_MULR, 14, 0, 26);
      6'd36: u = mk(OP_MULR, 15, 0, 27);
      6'd37: u = mk(OP_MULR, 16, 0, 28);
      6'd38: u = mk(OP_MULR, 17, 0, 29);
      6'd39: u = mk(OP_MULR, 18, 0, 30);
      6'd40: u = mk(OP_MULR, 19, 0, 31);
      6'd41: u = mk(OP_MULR, 20, 0, 32);
      6'd42: u = mk(OP_MUL, 9, 24, 21);
      6'd43: u = mk(OP_MUL, 10, 27, 22);
      6'd44: u = mk(OP_ADD, 21, 22, 21);
      6'd45: u = mk(OP_MUL, 11, 30, 22);
      6'd46: u = mk(OP_ADD, 21, 22, 21);
      6'd47: u = mk(OP_NEG, 21, 0, 33);
      6'd48: u = mk(OP_MUL, 9, 25, 21);
      6'd49: u = mk(OP_MUL, 10, 28, 22);
      6'd50: u = mk(OP_ADD, 21, 22, 21);
      6'd51: u = mk(OP_MUL, 11, 31, 22);
      6'd52: u = mk(OP_ADD, 21, 22, 21);
      6'd53: u = mk(OP_NEG, 21, 0, 34);
      6'd54: u = mk(OP_MUL, 9, 26, 21);
      6'd55: u = mk(OP_MUL, 10, 29, 22);
      6'd56: u = mk(OP_ADD, 21, 22, 21);
      6'd57: u = mk(OP_MUL, 11, 32, 22);
      6'd58: u = mk(OP_ADD, 21, 22, 21);
      6'd59: u = mk(OP_NEG, 21, 0, 35);
      default: u = mk(OP_END, 0, 0, 0);
    endcase
    return u;
  endfunction

endpackage

@@ rtl/core/affmi_mul.sv @@
module affmi_mul #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [affmi_pkg::RECIP_W-1:0] a,
  input  logic signed [affmi_pkg::RECIP_W-1:0] b,
  input  logic                              long_shift,
  output logic                              done,
  output logic [VALUE_WIDTH-1:0]            result
);
  localparam int AW = affmi_pkg::RECIP_W;
  localparam int PW = 2 * AW + 1;

  logic          busy_r, busy_nxt, fin_r, fin_nxt, done_r, done_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          neg_r, lsh_r;
  logic [AW-1:0] ua_r, ub_r;
  logic [PW-1:0] acc_r, acc_nxt;
  logic [VALUE_WIDTH-1:0] res_r, res_nxt;
  logic [15:0]   digit;
  logic [PW-1:0] part, rnd, q, lim, qs, mask;

  always_comb begin
    digit    = ub_r[{cnt_r, 4'b0000} +: 16];
    part     = PW'(ua_r * digit) << {cnt_r, 4'b0000};
    mask     = lsh_r ? ((PW'(1) << (2 * FRAC_BITS)) - PW'(1))
                     : ((PW'(1) << FRAC_BITS) - PW'(1));
    rnd      = acc_r + (neg_r ? mask : '0);
    q        = lsh_r ? (rnd >> (2 * FRAC_BITS)) : (rnd >> FRAC_BITS);
    lim      = (PW'(1) << (VALUE_WIDTH - 1)) - PW'(!neg_r);
    qs       = (q > lim) ? lim : q;
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = acc_r + part;
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd2) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      done_nxt = 1'b1;
      res_nxt  = neg_r ? (-qs[VALUE_WIDTH-1:0]) : qs[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    if (start) begin
      neg_r <= a[AW-1] ^ b[AW-1];
      ua_r  <= a[AW-1] ? AW'(-a) : AW'(a);
      ub_r  <= b[AW-1] ? AW'(-b) : AW'(b);
      lsh_r <= long_shift;
    end
  end

  assign done   = done_r;
  assign result = res_r;
endmodule

@@ rtl/core/affmi_div.sv @@
module affmi_div #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [VALUE_WIDTH-1:0]            divisor,
  output logic                              done,
  output logic [affmi_pkg::QUOT_W-1:0]      quotient
);
  localparam int TOP = 3 * FRAC_BITS;
  localparam int CW  = $clog2(TOP + 1);
  localparam int RW  = VALUE_WIDTH + 1;
  localparam int QW  = affmi_pkg::QUOT_W;

  logic          busy_r, done_r, sat_r;
  logic [CW-1:0] i_r;
  logic [RW-1:0] r_r, r_sh;
  logic [QW-1:0] q_r;
  logic [VALUE_WIDTH-1:0] d_r;
  logic          ge;

  always_comb begin
    r_sh = {r_r[RW-2:0], (i_r == CW'(TOP))};
    ge   = r_sh >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (i_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (i_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      i_r   <= CW'(TOP);
      r_r   <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
      d_r   <= divisor;
    end else if (busy_r) begin
      i_r   <= i_r - CW'(1);
      r_r   <= ge ? (r_sh - {1'b0, d_r}) : r_sh;
      q_r   <= {q_r[QW-2:0], ge};
      sat_r <= sat_r | (ge && (32'(i_r) >= 32'(QW)));
    end
  end

  assign done     = done_r;
  assign quotient = sat_r ? {QW{1'b1}} : q_r;
endmodule

@@ rtl/core/affine_matrix_inverse_core.sv @@
// After the last element the microcode runs 39 multiplies, 20 add/sub/negate steps,
// one divide and an end step, then reads out the results; a singular matrix leaves
// at the divide and goes straight to readout.
// Elements load one per cycle while busy is low; busy holds after the last one,
// until the twelfth result streams out. Multiplies use the single shared 48x16 unit.
// Reset (rst_n low, synchronous) clears control, threshold and reciprocal.
module affine_matrix_inverse_core #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  affmi_pkg::in_item_t  in_data,
  output logic                 out_valid,
  output affmi_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [30:0]          cfg_wdata
);
  localparam int VW = VALUE_WIDTH;
  localparam int RW = affmi_pkg::RECIP_W;
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
  localparam logic signed [63:0] OMAX = 64'sd2147483647;
  localparam logic signed [63:0] OMIN = -64'sd2147483648;

  affmi_pkg::state_t state_r, state_nxt;
  logic [affmi_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic [3:0]  k_r, k_nxt;
  logic        singular_r, singular_nxt;
  logic        neg_r, neg_nxt;
  logic signed [RW-1:0] recip_r, recip_nxt;
  logic [30:0] thr_r;
  logic        emit_r, emit_nxt;
  logic [3:0]  emit_k_r, emit_k_nxt;
  logic        out_valid_r;
  affmi_pkg::out_item_t out_r;
  affmi_pkg::uop_t uop;

  // scratch memory: two registered read ports, one write port
  logic [VW-1:0] mem [affmi_pkg::MEM_DEPTH];
  logic [VW-1:0] rd_a_r, rd_b_r;
  logic [affmi_pkg::MEM_AW-1:0] ra, rb, wa;
  logic [VW-1:0] wd;
  logic          we;

  logic          accept;
  logic          mul_start, mul_done, div_start, div_done;
  logic [VW-1:0] mul_res, mag;
  logic [affmi_pkg::QUOT_W-1:0] quot;
  logic signed [RW-1:0] mul_a, mul_b;
  logic signed [VW:0]   sum;
  logic signed [63:0]   load_v, res_v;
  logic [VW-1:0]        load_sat, sum_sat;
  logic [31:0]          res_sat;

  assign accept = start && !busy;
  assign uop    = affmi_pkg::rom(pc_r);

  // input saturation to the working width
  always_comb begin
    load_v = 64'(in_data.element_value);
    if (load_v > VMAX)      load_sat = VMAX[VW-1:0];
    else if (load_v < VMIN) load_sat = VMIN[VW-1:0];
    else                    load_sat = load_v[VW-1:0];
  end

  // saturating add / sub / negate
  always_comb begin
    case (uop.op)
      affmi_pkg::OP_ADD: sum = (VW+1)'(signed'(rd_a_r)) + (VW+1)'(signed'(rd_b_r));
      affmi_pkg::OP_SUB: sum = (VW+1)'(signed'(rd_a_r)) - (VW+1)'(signed'(rd_b_r));
      default:           sum = (VW+1)'(0) - (VW+1)'(signed'(rd_a_r));
    endcase
    if (sum[VW] != sum[VW-1]) sum_sat = sum[VW] ? {1'b1, {(VW-1){1'b0}}}
                                                : {1'b0, {(VW-1){1'b1}}};
    else                      sum_sat = sum[VW-1:0];
    mag = rd_a_r[VW-1] ? (-rd_a_r) : rd_a_r;
  end

  assign mul_a = RW'(signed'(rd_a_r));
  assign mul_b = (uop.op == affmi_pkg::OP_MULR) ? recip_r : RW'(signed'(rd_b_r));

  // result clamp to the 32-bit field
  always_comb begin
    res_v = 64'(signed'(rd_a_r));
    if (res_v > OMAX)      res_sat = OMAX[31:0];
    else if (res_v < OMIN) res_sat = OMIN[31:0];
    else                   res_sat = res_v[31:0];
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    k_nxt        = k_r;
    singular_nxt = singular_r;
    neg_nxt      = neg_r;
    recip_nxt    = recip_r;
    emit_nxt     = 1'b0;
    emit_k_nxt   = emit_k_r;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    we           = 1'b0;
    wa           = uop.d;
    wd           = sum_sat;
    ra           = uop.a;
    rb           = uop.b;
    case (state_r)
      affmi_pkg::ST_IDLE: begin
        if (accept) begin
          we = in_data.element_index < 4'(affmi_pkg::ELEM_COUNT);
          wa = affmi_pkg::MEM_AW'(in_data.element_index);
          wd = load_sat;
          if (in_data.last_element) begin
            pc_nxt    = '0;
            state_nxt = affmi_pkg::ST_FETCH;
          end
        end
      end
      affmi_pkg::ST_FETCH: state_nxt = affmi_pkg::ST_EXEC;
      affmi_pkg::ST_EXEC: begin
        case (uop.op)
          affmi_pkg::OP_ADD, affmi_pkg::OP_SUB, affmi_pkg::OP_NEG: begin
            we        = 1'b1;
            pc_nxt    = pc_r + 1'b1;
            state_nxt = affmi_pkg::ST_FETCH;
          end
          affmi_pkg::OP_MUL, affmi_pkg::OP_MULR: begin
            mul_start = 1'b1;
            state_nxt = affmi_pkg::ST_MULW;
          end
          affmi_pkg::OP_DIV: begin
            neg_nxt = rd_a_r[VW-1];
            if (64'(mag) <= 64'(thr_r)) begin
              singular_nxt = 1'b1;
              recip_nxt    = '0;
              k_nxt        = '0;
              state_nxt    = affmi_pkg::ST_OUT;
            end else begin
              div_start = 1'b1;
              state_nxt = affmi_pkg::ST_DIVW;
            end
          end
          default: begin
            singular_nxt = 1'b0;
            k_nxt        = '0;
            state_nxt    = affmi_pkg::ST_OUT;
          end
        endcase
      end
      affmi_pkg::ST_MULW: begin
        if (mul_done) begin
          we        = 1'b1;
          wd        = mul_res;
          pc_nxt    = pc_r + 1'b1;
          state_nxt = affmi_pkg::ST_FETCH;
        end
      end
      affmi_pkg::ST_DIVW: begin
        if (div_done) begin
          recip_nxt = neg_r ? -RW'(quot) : RW'(quot);
          pc_nxt    = pc_r + 1'b1;
          state_nxt = affmi_pkg::ST_FETCH;
        end
      end
      affmi_pkg::ST_OUT: begin
        ra         = affmi_pkg::A_INV + affmi_pkg::MEM_AW'(k_r);
        emit_nxt   = 1'b1;
        emit_k_nxt = k_r;
        k_nxt      = k_r + 4'd1;
        if (k_r == 4'(affmi_pkg::LAST_IDX)) state_nxt = affmi_pkg::ST_IDLE;
      end
      default: state_nxt = affmi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= affmi_pkg::ST_IDLE;
      pc_r        <= '0;
      k_r         <= '0;
      singular_r  <= 1'b0;
      neg_r       <= 1'b0;
      recip_r     <= '0;
      thr_r       <= '0;
      emit_r      <= 1'b0;
      emit_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      k_r         <= k_nxt;
      singular_r  <= singular_nxt;
      neg_r       <= neg_nxt;
      recip_r     <= recip_nxt;
      emit_r      <= emit_nxt;
      emit_k_r    <= emit_k_nxt;
      out_valid_r <= emit_r;
      if (cfg_we) thr_r <= cfg_wdata;
    end
  end

  // result transfer register
  always_ff @(posedge clk) begin
    if (emit_r) begin
      out_r.result_index <= emit_k_r;
      out_r.result_value <= singular_r ? 32'sd0 : signed'(res_sat);
      out_r.singular     <= singular_r;
      out_r.last_result  <= emit_k_r == 4'(affmi_pkg::LAST_IDX);
    end
  end

  affmi_mul #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mul_start),
    .a          (mul_a),
    .b          (mul_b),
    .long_shift (uop.op == affmi_pkg::OP_MULR),
    .done       (mul_done),
    .result     (mul_res)
  );

  affmi_div #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (mag),
    .done     (div_done),
    .quotient (quot)
  );

  assign busy      = (state_r != affmi_pkg::ST_IDLE) || emit_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_result |-> out_data.result_index == 4'(affmi_pkg::LAST_IDX))
    else $error("last flag on wrong index");
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |-> out_data.result_value == 32'sd0)
    else $error("singular result not zero");
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.last_element |=> busy)
    else $error("inversion did not start");
  a_mul_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_start && div_start))
    else $error("two units started together");
`endif
endmodule
